/* src/nfa_pkg.sv */
// ---------------------------------------------------------------------------
// nfa_pkg: shared types and constants
// Node descriptor layout, item kinds, controller states and command/status.
// ---------------------------------------------------------------------------
package nfa_pkg;

  localparam int NODE_COUNT = 64;
  localparam int NODE_W     = 6;
  localparam int SYM_W      = 7;
  localparam int CLASS_W    = 64;

  typedef enum logic [1:0] {
    KIND_WRITE_NODE  = 2'd0,
    KIND_WRITE_CLASS = 2'd1,
    KIND_START       = 2'd2,
    KIND_STEP        = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ET_EPS   = 2'd0,
    ET_LIT   = 2'd1,
    ET_CLASS = 2'd2,
    ET_NONE  = 2'd3
  } edge_t;

  typedef struct packed {
    logic              inv;
    logic              valid1;
    logic [NODE_W-1:0] next1;
    logic              valid0;
    logic [NODE_W-1:0] next0;
    logic [SYM_W-1:0]  sym;
    logic [1:0]        etype;
  } node_desc_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE,
    ST_CLOSE,
    ST_ACC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic scan_move;
    logic scan_close;
    logic commit_round;
    logic scan_acc;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic grew;
    logic kind_write;
    logic kind_start;
  } status_t;

endpackage

/* src/nfa_if.sv */
// ---------------------------------------------------------------------------
// nfa_in_if / nfa_out_if: valid/ready channels
// Input item and result item channels.
// ---------------------------------------------------------------------------
interface nfa_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [nfa_pkg::NODE_W-1:0]  node;
  logic [1:0]                  edge_type;
  logic [nfa_pkg::SYM_W-1:0]   symbol;
  logic [nfa_pkg::NODE_W-1:0]  first_next;
  logic                        first_valid;
  logic [nfa_pkg::NODE_W-1:0]  second_next;
  logic                        second_valid;
  logic                        invert_class;
  logic                        class_half;
  logic [nfa_pkg::CLASS_W-1:0] class_bits;
  modport source(output valid, kind, node, edge_type, symbol, first_next, first_valid,
                 second_next, second_valid, invert_class, class_half, class_bits,
                 input ready);
  modport sink(input valid, kind, node, edge_type, symbol, first_next, first_valid,
               second_next, second_valid, invert_class, class_half, class_bits,
               output ready);
endinterface

interface nfa_out_if;
  logic                           valid;
  logic                           ready;
  logic [nfa_pkg::NODE_COUNT-1:0] active_nodes;
  logic                           any_active;
  logic                           accepting;
  modport source(output valid, active_nodes, any_active, accepting, input ready);
  modport sink(input valid, active_nodes, any_active, accepting, output ready);
endinterface

/* src/nfa_active_set_stepper.sv */
// ---------------------------------------------------------------------------
// nfa_active_set_stepper: Thompson NFA step engine
// Loads node descriptors and class maps, then starts or steps an active set.
// ---------------------------------------------------------------------------
// Every item gives one result. Nodes are visited one per cycle from the node
// memory read port; each pass first primes the read port, then visits all 64 nodes.
// A write item takes one accept pass; a start takes
// (R+1) closure passes plus the accept pass, and a step one more move pass,
// where R is the longest epsilon chain grown.
module nfa_active_set_stepper (
  input logic     clk,
  input logic     rst,
  nfa_in_if.sink  in_ch,
  nfa_out_if.source out_ch
);

  nfa_pkg::cmd_t    cmd;
  nfa_pkg::status_t st;
  logic             in_ready;

  nfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  nfa_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .cmd         (cmd),
    .st          (st),
    .active_nodes(out_ch.active_nodes),
    .accepting   (out_ch.accepting)
  );

  assign out_ch.any_active = |out_ch.active_nodes;

endmodule

/* src/nfa_ctrl.sv */
// ---------------------------------------------------------------------------
// nfa_ctrl: controller
// Sequences move scan, closure rounds, accept scan and result transfer.
// ---------------------------------------------------------------------------
module nfa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  nfa_pkg::status_t st,
  output nfa_pkg::cmd_t    cmd
);

  nfa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= nfa_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      nfa_pkg::ST_IDLE: if (in_valid) begin
        if (st.kind_write) state_next = nfa_pkg::ST_ACC;
        else if (st.kind_start) state_next = nfa_pkg::ST_CLOSE;
        else state_next = nfa_pkg::ST_MOVE;
      end
      nfa_pkg::ST_MOVE:  if (st.scan_last) state_next = nfa_pkg::ST_CLOSE;
      nfa_pkg::ST_CLOSE: if (st.scan_last && !st.grew) state_next = nfa_pkg::ST_ACC;
      nfa_pkg::ST_ACC:   if (st.scan_last) state_next = nfa_pkg::ST_OUT;
      nfa_pkg::ST_OUT:   if (out_ready) state_next = nfa_pkg::ST_IDLE;
      default:           state_next = nfa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      nfa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load_item = in_valid;
      end
      nfa_pkg::ST_MOVE: begin
        cmd.scan_move = 1'b1;
        cmd.commit_round = st.scan_last;
      end
      nfa_pkg::ST_CLOSE: begin
        cmd.scan_close = 1'b1;
        cmd.commit_round = st.scan_last;
      end
      nfa_pkg::ST_ACC: cmd.scan_acc = 1'b1;
      nfa_pkg::ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

/* src/nfa_dp.sv */
// ---------------------------------------------------------------------------
// nfa_dp: datapath
// Node and class memories, active set, one node visited per cycle.
// ---------------------------------------------------------------------------
module nfa_dp (
  input  logic                           clk,
  input  logic                           rst,
  nfa_in_if.sink                         in_ch,
  input  nfa_pkg::cmd_t                  cmd,
  output nfa_pkg::status_t               st,
  output logic [nfa_pkg::NODE_COUNT-1:0] active_nodes,
  output logic                           accepting
);

  localparam int N = nfa_pkg::NODE_COUNT;

  nfa_pkg::node_desc_t        node_mem [N];
  logic [nfa_pkg::CLASS_W-1:0] class_mem [2*N];

  logic [N-1:0]               active;
  logic [N-1:0]               work;
  logic [N-1:0]               grown;
  logic [nfa_pkg::NODE_W-1:0] idx;
  logic [nfa_pkg::NODE_W-1:0] rd_addr;
  logic [nfa_pkg::SYM_W-1:0]  sym;
  logic                       acc;
  logic                       grew;
  logic                       phase;
  logic                       chg;

  nfa_pkg::node_desc_t         rd;
  logic [nfa_pkg::CLASS_W-1:0] crd;
  nfa_pkg::node_desc_t         wd;

  logic scan;
  logic last;
  logic hit;
  logic [N-1:0] add;

  assign scan = cmd.scan_move | cmd.scan_close | cmd.scan_acc;
  assign last = phase && (idx == nfa_pkg::NODE_W'(N - 1));

  // read one node ahead so rd lines up with idx on the next cycle
  assign rd_addr = phase ? idx + 1'b1 : idx;

  always_comb begin
    wd.etype  = in_ch.edge_type;
    wd.sym    = in_ch.symbol;
    wd.next0  = in_ch.first_next;
    wd.valid0 = in_ch.first_valid;
    wd.next1  = in_ch.second_next;
    wd.valid1 = in_ch.second_valid;
    wd.inv    = in_ch.invert_class;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item && in_ch.kind == nfa_pkg::KIND_WRITE_NODE &&
        {1'b0, in_ch.node} < (nfa_pkg::NODE_W+1)'(N))
      node_mem[in_ch.node] <= wd;
    if (cmd.load_item && in_ch.kind == nfa_pkg::KIND_WRITE_CLASS &&
        {1'b0, in_ch.node} < (nfa_pkg::NODE_W+1)'(N))
      class_mem[{in_ch.node, in_ch.class_half}] <= in_ch.class_bits;
    rd  <= node_mem[rd_addr];
    crd <= class_mem[{rd_addr, sym[nfa_pkg::SYM_W-1]}];
  end

  always_comb begin
    hit = 1'b0;
    add = '0;
    if (cmd.scan_move && active[idx]) begin
      if (rd.etype == nfa_pkg::ET_LIT) hit = (rd.sym == sym);
      else if (rd.etype == nfa_pkg::ET_CLASS) hit = rd.inv ^ crd[sym[5:0]];
      if (hit && rd.valid0 && {1'b0, rd.next0} < (nfa_pkg::NODE_W+1)'(N))
        add[rd.next0] = 1'b1;
    end
    if (cmd.scan_close && work[idx] && rd.etype == nfa_pkg::ET_EPS) begin
      if (rd.valid0 && {1'b0, rd.next0} < (nfa_pkg::NODE_W+1)'(N)) add[rd.next0] = 1'b1;
      if (rd.valid1 && {1'b0, rd.next1} < (nfa_pkg::NODE_W+1)'(N)) add[rd.next1] = 1'b1;
    end
  end

  assign chg = |(add & ~grown);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      phase  <= 1'b0;
      idx    <= '0;
    end else begin
      if (cmd.load_item) begin
        idx   <= '0;
        phase <= 1'b0;
        sym   <= in_ch.symbol;
        acc   <= 1'b0;
        grew  <= 1'b0;
        if (in_ch.kind == nfa_pkg::KIND_START) begin
          work  <= '0;
          grown <= '0;
          if ({1'b0, in_ch.node} < (nfa_pkg::NODE_W+1)'(N)) begin
            work[in_ch.node]  <= 1'b1;
            grown[in_ch.node] <= 1'b1;
          end
        end else begin
          work  <= '0;
          grown <= '0;
        end
      end else if (scan) begin
        if (!phase) phase <= 1'b1;
        else idx <= idx + 1'b1;
        if (phase) begin
          grown <= grown | add;
          if (chg) grew <= 1'b1;
          if (cmd.scan_acc && active[idx] && !rd.valid0) acc <= 1'b1;
        end
        if (last) begin
          idx   <= '0;
          phase <= 1'b0;
          grew  <= 1'b0;
          if (cmd.commit_round) begin
            work   <= grown | add;
            active <= grown | add;
          end
        end
      end
    end
  end

  assign st.scan_last  = last;
  assign st.grew       = grew | chg;
  assign st.kind_write = in_ch.kind == nfa_pkg::KIND_WRITE_NODE ||
                         in_ch.kind == nfa_pkg::KIND_WRITE_CLASS;
  assign st.kind_start = in_ch.kind == nfa_pkg::KIND_START;

  assign active_nodes = active;
  assign accepting    = acc;

endmodule
